// File: sv/http_request_header_parser_macros.svh
// Assertion macros for the HTTP request header parser.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef HTTP_REQUEST_HEADER_PARSER_MACROS_SVH
`define HTTP_REQUEST_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HRHP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HRHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/hrhp_pkg.sv
// Shared types, codes and suffix tables for the HTTP request header parser.
// No dependencies; used by every module of the block.
`default_nettype none

package hrhp_pkg;

  typedef enum logic [1:0] {
    KIND_PATH  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    METHOD_GET     = 2'd0,
    METHOD_PUT     = 2'd1,
    METHOD_POST    = 2'd2,
    METHOD_UNKNOWN = 2'd3
  } method_e;

  typedef enum logic [1:0] {
    ERR_NO_FIRST_SPACE  = 2'd0,
    ERR_NO_SECOND_SPACE = 2'd1,
    ERR_INVALID_PATH    = 2'd2,
    ERR_LINE_TOO_LONG   = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    PH_METHOD = 2'd0,
    PH_PATH   = 2'd1,
    PH_TAIL   = 2'd2,
    PH_HEADER = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       new_connection;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] path_byte;
    method_e    method;
    logic [3:0] mime_class;
    err_e       error_code;
  } out_item_t;

  // Suffix text collected after the last period of the path.
  typedef struct packed {
    logic            valid;
    logic [2:0]      len;
    logic [4:0][7:0] chars;
  } sfx_t;

  localparam logic [9:0] MaxLineReset = 10'd1023;
  localparam int unsigned SfxMaxLen   = 5;
  localparam int unsigned SfxCount    = 11;

  localparam logic [7:0] ChrLf    = 8'h0A;
  localparam logic [7:0] ChrCr    = 8'h0D;
  localparam logic [7:0] ChrSpace = 8'h20;
  localparam logic [7:0] ChrSlash = 8'h2F;
  localparam logic [7:0] ChrDot   = 8'h2E;

  // Method tokens, padded to four characters (padding never compared).
  localparam logic [7:0] TokGet  [4] = '{8'h47, 8'h45, 8'h54, 8'h00};
  localparam logic [7:0] TokPut  [4] = '{8'h50, 8'h55, 8'h54, 8'h00};
  localparam logic [7:0] TokPost [4] = '{8'h50, 8'h4F, 8'h53, 8'h54};

  localparam logic [3:0] MimeNone  = 4'd0;
  localparam logic [3:0] MimePlain = 4'd1;
  localparam logic [3:0] MimeHtml  = 4'd2;
  localparam logic [3:0] MimeXhtml = 4'd3;
  localparam logic [3:0] MimeCss   = 4'd4;
  localparam logic [3:0] MimeJs    = 4'd5;
  localparam logic [3:0] MimeSvg   = 4'd6;
  localparam logic [3:0] MimeGif   = 4'd7;
  localparam logic [3:0] MimePng   = 4'd8;
  localparam logic [3:0] MimeJpeg  = 4'd9;

  // Suffix text, first character in the low byte, lower case.
  localparam logic [39:0] SfxText [SfxCount] = '{
    40'h00_00_74_78_74,  // txt
    40'h00_6C_6D_74_68,  // html
    40'h00_00_6D_74_68,  // htm
    40'h6C_6D_74_68_78,  // xhtml
    40'h00_00_73_73_63,  // css
    40'h00_00_00_73_6A,  // js
    40'h00_00_67_76_73,  // svg
    40'h00_00_66_69_67,  // gif
    40'h00_00_67_6E_70,  // png
    40'h00_00_67_70_6A,  // jpg
    40'h00_67_65_70_6A   // jpeg
  };

  localparam logic [2:0] SfxLen [SfxCount] = '{
    3'd3, 3'd4, 3'd3, 3'd5, 3'd3, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4
  };

  localparam logic [3:0] SfxClass [SfxCount] = '{
    MimePlain, MimeHtml, MimeHtml, MimeXhtml, MimeCss, MimeJs,
    MimeSvg, MimeGif, MimePng, MimeJpeg, MimeJpeg
  };

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

endpackage

`default_nettype wire

// File: sv/http_request_header_parser.sv
// HTTP request line and header parser, one byte per transaction.
// An accepted byte goes from the input register through the parse step to the result
// register. Throughput: one byte per cycle; a stalled result holds the input.
// Reset (async, active low) clears the parser and sets max_line_length to 1023.
// Depends on hrhp_pkg, hrhp_parser, hrhp_mime_lookup and the assertion macros.
`default_nettype none

`include "http_request_header_parser_macros.svh"

module http_request_header_parser #(
  parameter int unsigned LINE_BUFFER = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hrhp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hrhp_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [9:0]          cfg_data_i
);

  localparam logic [16:0] LimitCap = 17'(LINE_BUFFER - 1);

  logic                in_valid_q, in_valid_d;
  hrhp_pkg::in_item_t  in_data_q;
  logic                out_valid_q, out_valid_d;
  hrhp_pkg::out_item_t out_data_q;
  logic [9:0]          max_line_q;
  logic [9:0]          limit;
  logic                in_accept, step;
  logic                res_valid;
  hrhp_pkg::out_item_t res;
  logic                halted;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_line_q <= hrhp_pkg::MaxLineReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_line_q <= cfg_data_i;
    end
  end

  assign limit = ({7'd0, max_line_q} > LimitCap) ? LimitCap[9:0] : max_line_q;

  // Advance the held byte whenever the result register is free or draining.
  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = res_valid;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_data_q <= in_data_i;
    end
    if (step && res_valid) begin
      out_data_q <= res;
    end
  end

  hrhp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_data_q),
    .limit_i     (limit),
    .res_valid_o (res_valid),
    .res_o       (res),
    .halted_o    (halted)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `HRHP_ASSERT_NOW(a_stall_only_when_blocked, in_stall_o,
                   in_valid_q && out_valid_q && out_stall_i,
                   "input stalled while the result register could drain")
  `HRHP_ASSERT_NEXT(a_halt_after_final, step && res_valid && res.kind != hrhp_pkg::KIND_PATH,
                    halted, "parser not halted after a final transaction")
  `HRHP_ASSERT_NOW(a_final_has_no_byte,
                   out_valid_o && out_data_o.kind != hrhp_pkg::KIND_PATH,
                   out_data_o.path_byte == 8'd0,
                   "final transaction carries a path byte")

endmodule

`default_nettype wire

// File: sv/hrhp_mime_lookup.sv
// Case-insensitive match of the collected path suffix against the suffix table.
// Depends on hrhp_pkg.
`default_nettype none

module hrhp_mime_lookup (
  input  hrhp_pkg::sfx_t   sfx_i,
  output logic [3:0]       mime_class_o
);

  always_comb begin
    logic found;
    logic hit;
    found        = 1'b0;
    mime_class_o = hrhp_pkg::MimeNone;
    for (int i = 0; i < hrhp_pkg::SfxCount; i++) begin
      hit = sfx_i.valid && (sfx_i.len == hrhp_pkg::SfxLen[i]);
      for (int k = 0; k < hrhp_pkg::SfxMaxLen; k++) begin
        if ((3'(k) < sfx_i.len) &&
            (hrhp_pkg::to_lower(sfx_i.chars[k]) != hrhp_pkg::SfxText[i][8*k +: 8])) begin
          hit = 1'b0;
        end
      end
      if (hit && !found) begin
        found        = 1'b1;
        mime_class_o = hrhp_pkg::SfxClass[i];
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/hrhp_parser.sv
// Per-byte parse step: parser state registers plus the combinational step logic.
// Depends on hrhp_pkg and hrhp_mime_lookup.
`default_nettype none

module hrhp_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  hrhp_pkg::in_item_t  item_i,
  input  logic [9:0]          limit_i,
  output logic                res_valid_o,
  output hrhp_pkg::out_item_t res_o,
  output logic                halted_o
);

  hrhp_pkg::phase_e phase_q, phase_d, phase_c;
  logic [9:0]       line_cnt_q, line_cnt_d, line_cnt_c;
  logic             last_cr_q, last_cr_d, last_cr_c;
  logic [2:0]       cand_q, cand_d, cand_c;
  logic [2:0]       mpos_q, mpos_d, mpos_c;
  logic [1:0]       plen_q, plen_d, plen_c;
  logic             pslash_q, pslash_d, pslash_c;
  hrhp_pkg::sfx_t   sfx_q, sfx_d, sfx_c;
  logic             halted_q, halted_d, halted_c;

  logic [7:0] b;
  logic       is_lf, is_sp, is_cr, is_slash, is_dot;
  logic       over, empty_line, path_bad;
  logic [3:0] mime_class;
  hrhp_pkg::method_e method_code;

  // New connection: work from cleared state; the suffix text itself is
  // always written before it is read.
  always_comb begin
    phase_c    = phase_q;
    line_cnt_c = line_cnt_q;
    last_cr_c  = last_cr_q;
    cand_c     = cand_q;
    mpos_c     = mpos_q;
    plen_c     = plen_q;
    pslash_c   = pslash_q;
    sfx_c      = sfx_q;
    halted_c   = halted_q;
    if (item_i.new_connection) begin
      phase_c     = hrhp_pkg::PH_METHOD;
      line_cnt_c  = '0;
      last_cr_c   = 1'b0;
      cand_c      = 3'b111;
      mpos_c      = '0;
      plen_c      = '0;
      pslash_c    = 1'b0;
      sfx_c.valid = 1'b0;
      sfx_c.len   = '0;
      halted_c    = 1'b0;
    end
  end

  assign b          = item_i.rx_byte;
  assign is_lf      = (b == hrhp_pkg::ChrLf);
  assign is_sp      = (b == hrhp_pkg::ChrSpace);
  assign is_cr      = (b == hrhp_pkg::ChrCr);
  assign is_slash   = (b == hrhp_pkg::ChrSlash);
  assign is_dot     = (b == hrhp_pkg::ChrDot);
  assign over       = (line_cnt_c >= limit_i);
  assign empty_line = (line_cnt_c == 10'd0) || ((line_cnt_c == 10'd1) && last_cr_c);
  assign path_bad   = !pslash_c || (plen_c < 2'd2);

  hrhp_mime_lookup u_mime (
    .sfx_i        (sfx_c),
    .mime_class_o (mime_class)
  );

  always_comb begin
    if (cand_c[0] && mpos_c == 3'd3) begin
      method_code = hrhp_pkg::METHOD_GET;
    end else if (cand_c[1] && mpos_c == 3'd3) begin
      method_code = hrhp_pkg::METHOD_PUT;
    end else if (cand_c[2] && mpos_c == 3'd4) begin
      method_code = hrhp_pkg::METHOD_POST;
    end else begin
      method_code = hrhp_pkg::METHOD_UNKNOWN;
    end
  end

  // Result of this byte.
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    if (!halted_c) begin
      if (is_lf) begin
        case (phase_c)
          hrhp_pkg::PH_METHOD: begin
            res_valid_o      = 1'b1;
            res_o.kind       = hrhp_pkg::KIND_ERROR;
            res_o.error_code = hrhp_pkg::ERR_NO_FIRST_SPACE;
          end
          hrhp_pkg::PH_PATH: begin
            res_valid_o      = 1'b1;
            res_o.kind       = hrhp_pkg::KIND_ERROR;
            res_o.error_code = hrhp_pkg::ERR_NO_SECOND_SPACE;
          end
          hrhp_pkg::PH_TAIL: begin
            if (path_bad) begin
              res_valid_o      = 1'b1;
              res_o.kind       = hrhp_pkg::KIND_ERROR;
              res_o.error_code = hrhp_pkg::ERR_INVALID_PATH;
            end
          end
          hrhp_pkg::PH_HEADER: begin
            if (empty_line) begin
              res_valid_o      = 1'b1;
              res_o.kind       = hrhp_pkg::KIND_DONE;
              res_o.method     = method_code;
              res_o.mime_class = mime_class;
            end
          end
          default: begin
            res_valid_o = 1'b0;
          end
        endcase
      end else if (over) begin
        res_valid_o      = 1'b1;
        res_o.kind       = hrhp_pkg::KIND_ERROR;
        res_o.error_code = hrhp_pkg::ERR_LINE_TOO_LONG;
      end else if (phase_c == hrhp_pkg::PH_PATH && !is_sp) begin
        res_valid_o     = 1'b1;
        res_o.kind      = hrhp_pkg::KIND_PATH;
        res_o.path_byte = b;
      end
    end
  end

  // Next parser state.
  always_comb begin
    phase_d    = phase_q;
    line_cnt_d = line_cnt_q;
    last_cr_d  = last_cr_q;
    cand_d     = cand_q;
    mpos_d     = mpos_q;
    plen_d     = plen_q;
    pslash_d   = pslash_q;
    sfx_d      = sfx_q;
    halted_d   = halted_q;
    if (step_i) begin
      phase_d    = phase_c;
      line_cnt_d = line_cnt_c;
      last_cr_d  = last_cr_c;
      cand_d     = cand_c;
      mpos_d     = mpos_c;
      plen_d     = plen_c;
      pslash_d   = pslash_c;
      sfx_d      = sfx_c;
      halted_d   = halted_c;
      if (!halted_c) begin
        if (is_lf) begin
          line_cnt_d = '0;
          last_cr_d  = 1'b0;
          if (phase_c == hrhp_pkg::PH_TAIL && !path_bad) begin
            phase_d = hrhp_pkg::PH_HEADER;
          end
        end else if (!over) begin
          line_cnt_d = line_cnt_c + 10'd1;
          last_cr_d  = is_cr;
          case (phase_c)
            hrhp_pkg::PH_METHOD: begin
              if (is_sp) begin
                phase_d = hrhp_pkg::PH_PATH;
              end else begin
                if (!(mpos_c < 3'd3 && b == hrhp_pkg::TokGet[mpos_c[1:0]])) begin
                  cand_d[0] = 1'b0;
                end
                if (!(mpos_c < 3'd3 && b == hrhp_pkg::TokPut[mpos_c[1:0]])) begin
                  cand_d[1] = 1'b0;
                end
                if (!(mpos_c < 3'd4 && b == hrhp_pkg::TokPost[mpos_c[1:0]])) begin
                  cand_d[2] = 1'b0;
                end
                if (mpos_c != 3'd7) begin
                  mpos_d = mpos_c + 3'd1;
                end
              end
            end
            hrhp_pkg::PH_PATH: begin
              if (is_sp) begin
                phase_d = hrhp_pkg::PH_TAIL;
              end else begin
                if (plen_c == 2'd0) begin
                  pslash_d = is_slash;
                end
                if (plen_c < 2'd2) begin
                  plen_d = plen_c + 2'd1;
                end
                if (is_dot) begin
                  sfx_d.valid = 1'b1;
                  sfx_d.len   = '0;
                end else if (is_slash) begin
                  sfx_d.valid = 1'b0;
                  sfx_d.len   = '0;
                end else if (sfx_c.valid) begin
                  if (sfx_c.len < 3'd5) begin
                    sfx_d.chars[sfx_c.len] = b;
                  end
                  if (sfx_c.len < 3'd6) begin
                    sfx_d.len = sfx_c.len + 3'd1;
                  end
                end
              end
            end
            default: begin
              phase_d = phase_c;
            end
          endcase
        end
        // Hold off everything after a completion or an error.
        if (res_valid_o && res_o.kind != hrhp_pkg::KIND_PATH) begin
          halted_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= hrhp_pkg::PH_METHOD;
      line_cnt_q <= '0;
      last_cr_q  <= 1'b0;
      cand_q     <= 3'b111;
      mpos_q     <= '0;
      plen_q     <= '0;
      pslash_q   <= 1'b0;
      sfx_q      <= '0;
      halted_q   <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      line_cnt_q <= line_cnt_d;
      last_cr_q  <= last_cr_d;
      cand_q     <= cand_d;
      mpos_q     <= mpos_d;
      plen_q     <= plen_d;
      pslash_q   <= pslash_d;
      sfx_q      <= sfx_d;
      halted_q   <= halted_d;
    end
  end

  assign halted_o = halted_q;

endmodule

`default_nettype wire

// File: tb/http_request_header_parser_check.sv
// Prediction and comparison for the HTTP request header parser testbench.
// Watches the byte, result and configuration channels; depends on hrhp_pkg.
module http_request_header_parser_check
  import hrhp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  in_item_t   in_data_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  out_item_t  out_data_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [9:0] cfg_data_i,
  output int         mismatches_o,
  output int         pending_o,
  output int         path_bytes_o,
  output int         done_o,
  output int         failed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [23:0] WordGet  = "GET";
  localparam logic [23:0] WordPut  = "PUT";
  localparam logic [31:0] WordPost = "POST";

  // Parser image
  logic [9:0] line_limit;
  phase_e     phase;
  logic [9:0] line_cnt;
  logic       last_cr;
  logic [2:0] cand;
  logic [2:0] mpos;
  logic [1:0] path_len;
  logic       path_slash;
  logic [7:0] sfx_chr [5];
  logic [2:0] sfx_len;
  logic       sfx_valid;
  logic       halted;

  out_item_t pending_results [$];

  initial begin
    mismatches_o = 0;
    path_bytes_o = 0;
    done_o       = 0;
    failed_o     = 0;
    pending_o    = 0;
  end

  task automatic clear_parser();
    phase      = PH_METHOD;
    line_cnt   = '0;
    last_cr    = 1'b0;
    cand       = 3'b111;
    mpos       = '0;
    path_len   = '0;
    path_slash = 1'b0;
    for (int i = 0; i < 5; i++) sfx_chr[i] = '0;
    sfx_len    = '0;
    sfx_valid  = 1'b0;
    halted     = 1'b0;
  endtask

  function automatic method_e method_of();
    if (cand[0] && mpos == 3'd3) return METHOD_GET;
    if (cand[1] && mpos == 3'd3) return METHOD_PUT;
    if (cand[2] && mpos == 3'd4) return METHOD_POST;
    return METHOD_UNKNOWN;
  endfunction

  // Suffix is matched lower-cased; length takes part in the match.
  function automatic logic [3:0] mime_of();
    logic [7:0]  c;
    logic [39:0] txt;
    logic [3:0]  m;
    if (!sfx_valid || sfx_len == 3'd0 || sfx_len > 3'd5) return MimeNone;
    txt = '0;
    for (int k = 0; k < 5; k++) begin
      c = sfx_chr[k];
      if (c >= "A" && c <= "Z") c = c + 8'd32;
      if (k < sfx_len) txt = {txt[31:0], c};
    end
    case (sfx_len)
      3'd2: m = (txt == "js") ? MimeJs : MimeNone;
      3'd3: begin
        case (txt)
          "txt":   m = MimePlain;
          "htm":   m = MimeHtml;
          "css":   m = MimeCss;
          "svg":   m = MimeSvg;
          "gif":   m = MimeGif;
          "png":   m = MimePng;
          "jpg":   m = MimeJpeg;
          default: m = MimeNone;
        endcase
      end
      3'd4: begin
        case (txt)
          "html":  m = MimeHtml;
          "jpeg":  m = MimeJpeg;
          default: m = MimeNone;
        endcase
      end
      3'd5: m = (txt == "xhtml") ? MimeXhtml : MimeNone;
      default: m = MimeNone;
    endcase
    return m;
  endfunction

  task automatic give(input out_item_t r);
    pending_results.push_back(r);
    if (r.kind != KIND_PATH) halted = 1'b1;
  endtask

  task automatic fail_with(input err_e code);
    out_item_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    give(r);
  endtask

  task automatic parse_byte(input in_item_t it);
    logic [7:0] b;
    logic       empty_line;
    out_item_t  r;
    int         p;
    b = it.rx_byte;
    r = '0;
    if (it.new_connection) clear_parser();
    if (halted) return;

    if (b == ChrLf) begin
      empty_line = (line_cnt == 10'd0) || (line_cnt == 10'd1 && last_cr);
      line_cnt = '0;
      last_cr = 1'b0;
      case (phase)
        PH_METHOD: fail_with(ERR_NO_FIRST_SPACE);
        PH_PATH:   fail_with(ERR_NO_SECOND_SPACE);
        PH_TAIL: begin
          if (!path_slash || path_len < 2'd2) fail_with(ERR_INVALID_PATH);
          else phase = PH_HEADER;
        end
        default: begin
          if (empty_line) begin
            r.kind = KIND_DONE;
            r.method = method_of();
            r.mime_class = mime_of();
            give(r);
          end
        end
      endcase
      return;
    end

    // Length check comes before any other use of a byte that is not a line feed
    if (line_cnt >= line_limit) begin
      fail_with(ERR_LINE_TOO_LONG);
      return;
    end
    line_cnt++;
    last_cr = (b == ChrCr);

    if (phase == PH_METHOD) begin
      if (b == ChrSpace) begin
        phase = PH_PATH;
      end else begin
        p = mpos;
        if (p >= 3 || b != WordGet[8*(2-p) +: 8]) cand[0] = 1'b0;
        if (p >= 3 || b != WordPut[8*(2-p) +: 8]) cand[1] = 1'b0;
        if (p >= 4 || b != WordPost[8*(3-p) +: 8]) cand[2] = 1'b0;
        if (mpos < 3'd7) mpos++;
      end
    end else if (phase == PH_PATH) begin
      if (b == ChrSpace) begin
        phase = PH_TAIL;
      end else begin
        if (path_len == 2'd0) path_slash = (b == ChrSlash);
        if (path_len < 2'd2) path_len++;
        if (b == ChrDot) begin
          sfx_valid = 1'b1;
          sfx_len = '0;
        end else if (b == ChrSlash) begin
          sfx_valid = 1'b0;
          sfx_len = '0;
        end else if (sfx_valid) begin
          if (sfx_len < 3'd5) sfx_chr[sfx_len] = b;
          if (sfx_len < 3'd6) sfx_len++;
        end
        r.kind = KIND_PATH;
        r.path_byte = b;
        give(r);
      end
    end
  endtask

  task automatic compare_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result: kind %0d, path_byte %0h", got.kind, got.path_byte);
      mismatches_o++;
      return;
    end
    want = pending_results.pop_front();
    case (want.kind)
      KIND_PATH: path_bytes_o++;
      KIND_DONE: done_o++;
      default:   failed_o++;
    endcase
    if (got.kind !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, got.kind);
      mismatches_o++;
    end
    if (got.path_byte !== want.path_byte) begin
      $error("path_byte: expected %0h, got %0h", want.path_byte, got.path_byte);
      mismatches_o++;
    end
    if (got.method !== want.method) begin
      $error("method: expected %0d, got %0d", want.method, got.method);
      mismatches_o++;
    end
    if (got.mime_class !== want.mime_class) begin
      $error("mime_class: expected %0d, got %0d", want.mime_class, got.mime_class);
      mismatches_o++;
    end
    if (got.error_code !== want.error_code) begin
      $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
      mismatches_o++;
    end
  endtask

  // Retire results before predicting: a byte taken at this edge cannot
  // have its result on the output yet.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_limit = MaxLineReset;
      clear_parser();
      pending_results.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) compare_result(out_data_i);
      if (cfg_valid_i && cfg_ready_i) line_limit = cfg_data_i;
      if (in_valid_i && !in_stall_i) parse_byte(in_data_i);
      pending_o <= pending_results.size();
    end
  end

endmodule

// File: tb/http_request_header_parser_test.sv
// Top of the HTTP request header parser testbench: clock, reset, byte stream
// stimulus and verdict. Depends on hrhp_pkg and http_request_header_parser_check.
module http_request_header_parser_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hrhp_pkg::*;

  localparam int QuietLimit = 1000;
  localparam int PhaseBytes = 70;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [9:0] cfg_data = '0;

  int mismatches;
  int pending;
  int path_bytes;
  int requests_done;
  int requests_failed;
  int bytes_sent = 0;
  int limits_tried = 0;
  int burst_left = 0;
  bit calm = 1'b0;
  int stall_run = 0;
  int stall_level = 0;

  logic [7:0] req_bytes [$];
  string suffix_words [14] = '{"txt", "html", "htm", "xhtml", "css", "js", "svg",
                               "gif", "png", "jpg", "jpeg", "jpegs", "tx", "xml"};

  http_request_header_parser uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  http_request_header_parser_check parse_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .path_bytes_o (path_bytes),
    .done_o       (requests_done),
    .failed_o     (requests_failed)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Result side: stretches of free flow, light and heavy random stalling, and a regular stall pattern
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_level = $urandom_range(0, 3);
      stall_run = $urandom_range(5, 60);
    end
    stall_run--;
    case (stall_level)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_run % 3 != 0);
    endcase
  end

  initial begin : watchdog
    int quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("http_request_header_parser_test failed");
    $finish;
  end

  task automatic put_byte(input logic [7:0] b, input logic fresh);
    in_valid <= 1'b1;
    in_data <= '{rx_byte: b, new_connection: fresh};
    do @(posedge clk_i); while (in_stall);
    bytes_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = calm ? 200 : $urandom_range(0, 12);
    end
  endtask

  // Hold the stream until every result is out, plus the pipeline depth
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [9:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limits_tried++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
  endtask

  task automatic add_letters(input int n);
    logic [7:0] c;
    repeat (n) begin
      c = 8'h61 + 8'($urandom_range(0, 25));
      if ($urandom_range(0, 4) == 0) c = c - 8'd32;
      req_bytes.push_back(c);
    end
  endtask

  task automatic add_eol();
    if ($urandom_range(0, 3) != 0) req_bytes.push_back(ChrCr);
    req_bytes.push_back(ChrLf);
  endtask

  task automatic add_suffix();
    string      w;
    logic [7:0] c;
    w = suffix_words[$urandom_range(0, 13)];
    for (int i = 0; i < w.len(); i++) begin
      c = w[i];
      if ($urandom_range(0, 3) == 0) c = c - 8'd32;
      req_bytes.push_back(c);
    end
  endtask

  task automatic send_request();
    foreach (req_bytes[i]) put_byte(req_bytes[i], i == 0);
    req_bytes.delete();
  endtask

  task automatic build_request();
    case ($urandom_range(0, 11))
      0, 1, 2: add_text("GET");
      3, 4:    add_text("PUT");
      5, 6:    add_text("POST");
      7:       add_text("GE");
      8:       add_text("POSTT");
      9:       add_text("Get");
      default: add_letters($urandom_range(0, 5));
    endcase
    req_bytes.push_back(ChrSpace);
    if ($urandom_range(0, 9) != 0) req_bytes.push_back(ChrSlash);
    repeat ($urandom_range(0, 2)) begin
      add_letters($urandom_range(1, 4));
      req_bytes.push_back(ChrSlash);
    end
    add_letters($urandom_range(0, 4));
    case ($urandom_range(0, 7))
      0, 1, 2, 3, 4: begin
        req_bytes.push_back(ChrDot);
        add_suffix();
      end
      5: begin
        req_bytes.push_back(ChrDot);
        repeat ($urandom_range(0, 7)) req_bytes.push_back(8'($urandom_range(0, 255)));
      end
      6: begin
        req_bytes.push_back(ChrDot);
        add_suffix();
        req_bytes.push_back(ChrSlash);
        add_letters($urandom_range(0, 3));
      end
      default: ;
    endcase
    if ($urandom_range(0, 7) == 0) req_bytes.push_back(ChrCr);
    req_bytes.push_back(ChrSpace);
    add_text($urandom_range(0, 1) ? "HTTP/1.0" : "H");
    add_eol();
    repeat ($urandom_range(0, 2)) begin
      add_letters($urandom_range(1, 6));
      add_text(": ");
      add_letters($urandom_range(0, 8));
      add_eol();
    end
    add_eol();
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: begin
        // raw bytes, connection restarts scattered anywhere
        repeat ($urandom_range(1, 10))
          put_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      1: begin
        build_request();
        repeat ($urandom_range(1, req_bytes.size() - 1)) void'(req_bytes.pop_back());
        send_request();
      end
      2: begin
        add_text($urandom_range(0, 1) ? "GET / H\r\n" : "PUT abc H\n");
        send_request();
      end
      default: begin
        build_request();
        req_bytes[$urandom_range(0, req_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        send_request();
      end
    endcase
  endtask

  initial begin : stimulus
    logic [9:0] limit_plan [6];
    int         start;
    limit_plan = '{10'd1023, 10'd1, 10'd512, 10'($urandom_range(8, 30)),
                   10'($urandom_range(2, 1022)), 10'd1023};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: no first space, no second space, short path with extreme
    // byte values, then a POST completion with a byte after it
    add_text("\n");
    send_request();
    add_text("G \n");
    send_request();
    req_bytes = '{8'hFF, ChrSpace, 8'h00, ChrSpace, ChrLf};
    send_request();
    add_text("POST /.Js \r\n\r\nX");
    send_request();

    foreach (limit_plan[k]) begin
      set_limit(limit_plan[k]);
      calm = (k == 2);
      start = bytes_sent;
      while (bytes_sent - start < PhaseBytes) begin
        if ($urandom_range(0, 4) == 0) begin
          send_noise();
        end else begin
          build_request();
          send_request();
        end
      end
    end

    drain();
    $display("Sent %0d bytes under %0d line limits", bytes_sent, limits_tried);
    $display("Results: %0d path bytes, %0d requests completed, %0d errors",
             path_bytes, requests_done, requests_failed);
    if (mismatches == 0) begin
      $display("http_request_header_parser_test passed");
    end else begin
      $display("http_request_header_parser_test failed");
    end
    $finish;
  end

endmodule
